// File: hdl/lrutlb_pkg.sv
// Shared types and constants for the LRU TLB with dirty write-back report.
`default_nettype none

package lrutlb_pkg;

  localparam int CFG_W = 5;
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  typedef struct packed {
    logic update;
    logic insert;
    logic any_match;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// File: hdl/lrutlb_cell.sv
// One recency-ordered TLB cell: holds an entry and shifts in from its younger neighbor.
`default_nettype none

module lrutlb_cell #(
  parameter int PAGE_BITS  = 8,
  parameter int FRAME_BITS = 8
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire lrutlb_pkg::cell_ctrl_t ctrl,
  input  wire logic                   kill,
  input  wire logic [PAGE_BITS-1:0]   cmp_page,
  input  wire logic                   seen_in,
  output logic                        seen_out,
  output logic                        match,
  input  wire logic                   prev_valid,
  input  wire logic [PAGE_BITS-1:0]   prev_page,
  input  wire logic [FRAME_BITS-1:0]  prev_frame,
  input  wire logic                   prev_dirty,
  output logic                        valid,
  output logic [PAGE_BITS-1:0]        page,
  output logic [FRAME_BITS-1:0]       frame,
  output logic                        dirty,
  output logic                        wb_flag,
  output logic [PAGE_BITS-1:0]        wb_page
);

  logic                  valid_r, valid_nxt;
  logic                  dirty_r, dirty_nxt;
  logic [PAGE_BITS-1:0]  page_r, page_nxt;
  logic [FRAME_BITS-1:0] frame_r, frame_nxt;
  logic                  shift;
  logic                  sh_valid;
  logic                  sh_dirty;

  assign match    = valid_r && (page_r == cmp_page);
  assign seen_out = seen_in | match;
  assign shift    = ctrl.any_match ? ~seen_in : ctrl.insert;

  always_comb begin
    sh_valid  = shift ? prev_valid : valid_r;
    sh_dirty  = shift ? prev_dirty : dirty_r;
    page_nxt  = shift ? prev_page  : page_r;
    frame_nxt = shift ? prev_frame : frame_r;
    valid_nxt = sh_valid & ~kill;
    dirty_nxt = sh_dirty & ~kill;
  end

  assign wb_flag = kill & sh_valid & sh_dirty;
  assign wb_page = wb_flag ? page_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      dirty_r <= 1'b0;
    end else if (ctrl.update) begin
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      page_r  <= page_nxt;
      frame_r <= frame_nxt;
    end
  end

  assign valid = valid_r;
  assign page  = page_r;
  assign frame = frame_r;
  assign dirty = dirty_r;

endmodule

`default_nettype wire

// File: hdl/lru_tlb_with_dirty_writeback.sv
// Top level of the fully associative LRU TLB with dirty write-back report.
//
// Channel   Handshake                 Payload
// input     start, busy               in_op, in_page, in_frame, in_is_write
// result    out_valid (1-cycle)       out_hit, out_hit_frame, out_writeback_valid,
//                                     out_writeback_page
// config    cfg_valid, cfg_ready      cfg_entries_in_use
//
// Each item passes through the EXEC state, which compares all cells and updates the recency
// chain, and then the result register, which presents the result while the next item may be accepted.
// The chain keeps entries ordered from most to least recently used.
// Reset (synchronous, rst_n low) empties the TLB and sets the capacity to 16.
// Results cannot be stalled; configuration writes are always ready.
`default_nettype none

module lru_tlb_with_dirty_writeback #(
  parameter int TLB_ENTRIES = 16,
  parameter int PAGE_BITS   = 8,
  parameter int FRAME_BITS  = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_op,
  input  wire logic [PAGE_BITS-1:0]         in_page,
  input  wire logic [FRAME_BITS-1:0]        in_frame,
  input  wire logic                         in_is_write,
  output logic                              out_valid,
  output logic                              out_hit,
  output logic [FRAME_BITS-1:0]             out_hit_frame,
  output logic                              out_writeback_valid,
  output logic [PAGE_BITS-1:0]              out_writeback_page,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [lrutlb_pkg::CFG_W-1:0] cfg_entries_in_use
);

  localparam int OCC_W = $clog2(TLB_ENTRIES + 1);
  localparam int CMP_W = (OCC_W > lrutlb_pkg::CFG_W) ? OCC_W : lrutlb_pkg::CFG_W;

  lrutlb_pkg::state_t state_r, state_nxt;

  logic [lrutlb_pkg::CFG_W-1:0] cfg_r;
  logic [OCC_W-1:0]             occ_r, occ_nxt, occ_red;
  logic                         op_r;
  logic [PAGE_BITS-1:0]         page_r;
  logic [FRAME_BITS-1:0]        frame_r;
  logic                         wr_r;

  logic                         out_valid_r;
  logic                         out_hit_r;
  logic [FRAME_BITS-1:0]        out_hit_frame_r;
  logic                         out_wb_valid_r;
  logic [PAGE_BITS-1:0]         out_wb_page_r;

  logic [TLB_ENTRIES:0]         seen;
  logic [TLB_ENTRIES:0]         ch_valid;
  logic [TLB_ENTRIES:0]         ch_dirty;
  logic [PAGE_BITS-1:0]         ch_page  [TLB_ENTRIES+1];
  logic [FRAME_BITS-1:0]        ch_frame [TLB_ENTRIES+1];
  logic [TLB_ENTRIES-1:0]       cell_match;
  logic [TLB_ENTRIES-1:0]       kill;
  logic [TLB_ENTRIES-1:0]       wb_flag;
  logic [PAGE_BITS-1:0]         wb_pg [TLB_ENTRIES];

  lrutlb_pkg::cell_ctrl_t       ctrl;
  logic                         is_insert;
  logic                         any_match;
  logic                         evict;
  logic                         wb_end;
  logic [FRAME_BITS-1:0]        hit_frame;
  logic                         hit_dirty;
  logic                         wb_any;
  logic [PAGE_BITS-1:0]         wb_page;
  logic [CMP_W-1:0]             cfg_ext;
  logic [CMP_W-1:0]             cap;
  logic [CMP_W-1:0]             occ_ext;

  assign busy      = (state_r == lrutlb_pkg::ST_EXEC);
  assign cfg_ready = 1'b1;
  assign is_insert = (op_r == lrutlb_pkg::OP_INSERT);
  assign any_match = seen[TLB_ENTRIES];

  always_comb begin
    unique case (state_r)
      lrutlb_pkg::ST_IDLE: state_nxt = start ? lrutlb_pkg::ST_EXEC : lrutlb_pkg::ST_IDLE;
      lrutlb_pkg::ST_EXEC: state_nxt = lrutlb_pkg::ST_IDLE;
      default:             state_nxt = lrutlb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cfg_ext = CMP_W'(cfg_r);
    if (cfg_ext == '0) begin
      cap = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(TLB_ENTRIES)) begin
      cap = CMP_W'(TLB_ENTRIES);
    end else begin
      cap = cfg_ext;
    end
    occ_red = occ_r - OCC_W'(any_match);
    occ_ext = CMP_W'(occ_red);
    evict   = is_insert && (occ_ext >= cap);
    occ_nxt = is_insert ? (occ_red - OCC_W'(evict) + OCC_W'(1)) : occ_r;
    wb_end  = evict && (occ_red == OCC_W'(TLB_ENTRIES)) &&
              ch_valid[TLB_ENTRIES] && ch_dirty[TLB_ENTRIES];
  end

  always_comb begin
    hit_frame = '0;
    hit_dirty = 1'b0;
    wb_any    = wb_end;
    wb_page   = wb_end ? ch_page[TLB_ENTRIES] : '0;
    for (int k = 0; k < TLB_ENTRIES; k++) begin
      hit_frame = hit_frame | (cell_match[k] ? ch_frame[k+1] : '0);
      hit_dirty = hit_dirty | (cell_match[k] & ch_dirty[k+1]);
      wb_any    = wb_any | wb_flag[k];
      wb_page   = wb_page | wb_pg[k];
    end
  end

  assign ctrl.update    = busy;
  assign ctrl.insert    = is_insert;
  assign ctrl.any_match = any_match;

  assign seen[0]     = 1'b0;
  assign ch_valid[0] = 1'b1;
  assign ch_page[0]  = page_r;
  assign ch_frame[0] = is_insert ? frame_r : hit_frame;
  assign ch_dirty[0] = is_insert ? wr_r : hit_dirty;

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    assign kill[i] = evict && (occ_red == OCC_W'(i));

    lrutlb_cell #(
      .PAGE_BITS  (PAGE_BITS),
      .FRAME_BITS (FRAME_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .kill       (kill[i]),
      .cmp_page   (page_r),
      .seen_in    (seen[i]),
      .seen_out   (seen[i+1]),
      .match      (cell_match[i]),
      .prev_valid (ch_valid[i]),
      .prev_page  (ch_page[i]),
      .prev_frame (ch_frame[i]),
      .prev_dirty (ch_dirty[i]),
      .valid      (ch_valid[i+1]),
      .page       (ch_page[i+1]),
      .frame      (ch_frame[i+1]),
      .dirty      (ch_dirty[i+1]),
      .wb_flag    (wb_flag[i]),
      .wb_page    (wb_pg[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lrutlb_pkg::ST_IDLE;
      cfg_r       <= lrutlb_pkg::CFG_RESET;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= busy;
      if (cfg_valid && cfg_ready) begin
        cfg_r <= cfg_entries_in_use;
      end
      if (busy) begin
        occ_r <= occ_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_r    <= in_op;
      page_r  <= in_page;
      frame_r <= in_frame;
      wr_r    <= in_is_write;
    end
    if (busy) begin
      out_hit_r       <= !is_insert && any_match;
      out_hit_frame_r <= (!is_insert && any_match) ? hit_frame : '0;
      out_wb_valid_r  <= is_insert && wb_any;
      out_wb_page_r   <= is_insert ? wb_page : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_hit_frame       = out_hit_frame_r;
  assign out_writeback_valid = out_wb_valid_r;
  assign out_writeback_page  = out_wb_page_r;

`ifndef SYNTH
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == lrutlb_pkg::ST_EXEC))
    else $error("Result strobe without a preceding update cycle.");

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(TLB_ENTRIES))
    else $error("Occupancy exceeds the number of entries.");

  a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(ch_valid[TLB_ENTRIES:1]) == int'(occ_r))
    else $error("Valid cells disagree with occupancy.");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> $onehot0(cell_match))
    else $error("A page matches more than one entry.");

  a_hit_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> !out_writeback_valid)
    else $error("A lookup reported a write-back.");
`endif

endmodule

`default_nettype wire

// File: tb/tlb_response_checker.sv
// Checker for the LRU TLB: mirrors the TLB contents and compares every response item.
module tlb_response_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         in_op,
  input  logic [7:0]                   in_page,
  input  logic [7:0]                   in_frame,
  input  logic                         in_is_write,
  input  logic                         out_valid,
  input  logic                         out_hit,
  input  logic [7:0]                   out_hit_frame,
  input  logic                         out_writeback_valid,
  input  logic [7:0]                   out_writeback_page,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [lrutlb_pkg::CFG_W-1:0] cfg_entries_in_use,
  output int                           fail_count,
  output int                           responses_due
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS = 16;

  typedef struct packed {
    logic       hit;
    logic [7:0] hit_frame;
    logic       wb_valid;
    logic [7:0] wb_page;
  } tlb_response_t;

  tlb_response_t                response_queue[$];
  logic [lrutlb_pkg::CFG_W-1:0] capacity_reg;
  logic                         slot_valid[NUM_SLOTS];
  logic [7:0]                   slot_page[NUM_SLOTS];
  logic [7:0]                   slot_frame[NUM_SLOTS];
  logic                         slot_dirty[NUM_SLOTS];
  int                           slot_rank[NUM_SLOTS];
  int                           fill_level;

  task automatic remove_slot(input int idx);
    int r;
    r = slot_rank[idx];
    slot_valid[idx] = 1'b0;
    slot_dirty[idx] = 1'b0;
    for (int j = 0; j < NUM_SLOTS; j++) begin
      if (slot_valid[j] && slot_rank[j] > r) slot_rank[j]--;
    end
    if (fill_level > 0) fill_level--;
  endtask

  task automatic translate_and_update(input logic op, input logic [7:0] page,
                                      input logic [7:0] frame, input logic is_write,
                                      output tlb_response_t resp);
    int  r;
    int  lru;
    int  cap;
    int  free_slot;
    bit  found;
    resp = '0;
    if (op == lrutlb_pkg::OP_LOOKUP) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_valid[i] && slot_page[i] == page) begin
          r = slot_rank[i];
          resp.hit = 1'b1;
          resp.hit_frame = slot_frame[i];
          for (int j = 0; j < NUM_SLOTS; j++) begin
            if (slot_valid[j] && slot_rank[j] < r) slot_rank[j]++;
          end
          slot_rank[i] = 0;
          break;
        end
      end
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_valid[i] && slot_page[i] == page) begin
          remove_slot(i);
          break;
        end
      end
      cap = int'(capacity_reg);
      if (cap == 0) cap = 1;
      if (cap > NUM_SLOTS) cap = NUM_SLOTS;
      if (fill_level >= cap) begin
        found = 1'b0;
        lru = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_valid[i] && (!found || slot_rank[i] > slot_rank[lru])) begin
            lru = i;
            found = 1'b1;
          end
        end
        if (found) begin
          if (slot_dirty[lru]) begin
            resp.wb_valid = 1'b1;
            resp.wb_page = slot_page[lru];
          end
          remove_slot(lru);
        end
      end
      free_slot = -1;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!slot_valid[i]) begin
          free_slot = i;
          break;
        end
      end
      if (free_slot >= 0) begin
        for (int j = 0; j < NUM_SLOTS; j++) begin
          if (slot_valid[j]) slot_rank[j]++;
        end
        slot_valid[free_slot] = 1'b1;
        slot_page[free_slot] = page;
        slot_frame[free_slot] = frame;
        slot_dirty[free_slot] = is_write;
        slot_rank[free_slot] = 0;
        fill_level++;
      end
    end
  endtask

  initial begin
    fail_count = 0;
    responses_due = 0;
  end

  always @(posedge clk) begin
    tlb_response_t due;
    tlb_response_t got;
    if (!rst_n) begin
      capacity_reg = lrutlb_pkg::CFG_RESET;
      fill_level = 0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_valid[i] = 1'b0;
        slot_dirty[i] = 1'b0;
        slot_page[i] = '0;
        slot_frame[i] = '0;
        slot_rank[i] = 0;
      end
      response_queue.delete();
      responses_due = 0;
    end else begin
      if (out_valid) begin
        got = '{out_hit, out_hit_frame, out_writeback_valid, out_writeback_page};
        if (response_queue.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: response item with none expected: hit=%0d frame=%02h wb=%0d page=%02h",
                     $realtime, got.hit, got.hit_frame, got.wb_valid, got.wb_page);
          fail_count++;
        end else begin
          due = response_queue.pop_front();
          if (got !== due) begin
            if (fail_count < 10)
              $display({"%0t: response mismatch: expected hit=%0d frame=%02h wb=%0d page=%02h,",
                        " got hit=%0d frame=%02h wb=%0d page=%02h"}, $realtime,
                       due.hit, due.hit_frame, due.wb_valid, due.wb_page,
                       got.hit, got.hit_frame, got.wb_valid, got.wb_page);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        translate_and_update(in_op, in_page, in_frame, in_is_write, due);
        response_queue = {response_queue, due};
      end
      if (cfg_valid && cfg_ready) capacity_reg = cfg_entries_in_use;
      responses_due = response_queue.size();
    end
  end

endmodule

// File: tb/tb_lru_tlb_with_dirty_writeback.sv
// Testbench top for the LRU TLB: drives lookup and insert items and capacity writes, and gives the verdict.
module tb_lru_tlb_with_dirty_writeback;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 2000;
  localparam int NUM_PHASES = 10;
  localparam int PHASE_ITEMS = 45;

  logic                         clk;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  logic                         in_op;
  logic [7:0]                   in_page;
  logic [7:0]                   in_frame;
  logic                         in_is_write;
  logic                         out_valid;
  logic                         out_hit;
  logic [7:0]                   out_hit_frame;
  logic                         out_writeback_valid;
  logic [7:0]                   out_writeback_page;
  logic                         cfg_valid;
  logic                         cfg_ready;
  logic [lrutlb_pkg::CFG_W-1:0] cfg_entries_in_use;
  int                           fail_count;
  int                           responses_due;
  int                           idle_cycles;
  int                           burst_left;

  lru_tlb_with_dirty_writeback DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_page             (in_page),
    .in_frame            (in_frame),
    .in_is_write         (in_is_write),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_hit_frame       (out_hit_frame),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_page  (out_writeback_page),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_entries_in_use  (cfg_entries_in_use)
  );

  tlb_response_checker checker_inst (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_op               (in_op),
    .in_page             (in_page),
    .in_frame            (in_frame),
    .in_is_write         (in_is_write),
    .out_valid           (out_valid),
    .out_hit             (out_hit),
    .out_hit_frame       (out_hit_frame),
    .out_writeback_valid (out_writeback_valid),
    .out_writeback_page  (out_writeback_page),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_entries_in_use  (cfg_entries_in_use),
    .fail_count          (fail_count),
    .responses_due       (responses_due)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("lru_tlb_with_dirty_writeback regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_access(input logic op, input logic [7:0] page,
                             input logic [7:0] frame, input logic is_write);
    bit taken;
    start <= 1'b1;
    in_op <= op;
    in_page <= page;
    in_frame <= frame;
    in_is_write <= is_write;
    do begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic paced_access(input logic op, input logic [7:0] page,
                              input logic [7:0] frame, input logic is_write);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    send_access(op, page, frame, is_write);
    burst_left--;
  endtask

  task automatic drain_responses();
    start <= 1'b0;
    do @(negedge clk); while (responses_due != 0);
    repeat (3) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_capacity(input logic [lrutlb_pkg::CFG_W-1:0] value);
    bit taken;
    drain_responses();
    cfg_valid <= 1'b1;
    cfg_entries_in_use <= value;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [lrutlb_pkg::CFG_W-1:0] phase_caps[NUM_PHASES];
    logic [7:0]                   page_base;
    logic [7:0]                   page;
    logic                         op;
    int                           span;

    phase_caps = '{5'd16, 5'd1, 5'd31, 5'd3, 5'd0, 5'd8, 5'd20, 5'd2, 5'd0, 5'd0};
    phase_caps[8] = 5'($urandom_range(0, 31));
    phase_caps[9] = 5'($urandom_range(4, 17));

    rst_n = 1'b0;
    start = 1'b0;
    in_op = lrutlb_pkg::OP_LOOKUP;
    in_page = '0;
    in_frame = '0;
    in_is_write = 1'b0;
    cfg_valid = 1'b0;
    cfg_entries_in_use = '0;
    burst_left = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_access(lrutlb_pkg::OP_LOOKUP, 8'h00, 8'hFF, 1'b1);
    send_access(lrutlb_pkg::OP_INSERT, 8'h00, 8'h00, 1'b0);
    send_access(lrutlb_pkg::OP_INSERT, 8'hFF, 8'hFF, 1'b1);
    send_access(lrutlb_pkg::OP_LOOKUP, 8'h00, 8'h00, 1'b0);
    send_access(lrutlb_pkg::OP_LOOKUP, 8'hFF, 8'h00, 1'b0);
    send_access(lrutlb_pkg::OP_INSERT, 8'hFF, 8'h5A, 1'b0);
    send_access(lrutlb_pkg::OP_LOOKUP, 8'hFF, 8'hA5, 1'b1);

    write_capacity(5'd2);
    send_access(lrutlb_pkg::OP_INSERT, 8'h10, 8'hF1, 1'b1);
    send_access(lrutlb_pkg::OP_INSERT, 8'h20, 8'hF2, 1'b1);
    send_access(lrutlb_pkg::OP_INSERT, 8'h30, 8'hF3, 1'b0);
    send_access(lrutlb_pkg::OP_INSERT, 8'h20, 8'hE2, 1'b0);
    send_access(lrutlb_pkg::OP_LOOKUP, 8'h30, 8'h00, 1'b0);
    send_access(lrutlb_pkg::OP_LOOKUP, 8'h10, 8'h00, 1'b0);

    write_capacity(5'd0);
    send_access(lrutlb_pkg::OP_INSERT, 8'h40, 8'h44, 1'b1);
    send_access(lrutlb_pkg::OP_INSERT, 8'h41, 8'h45, 1'b1);
    send_access(lrutlb_pkg::OP_LOOKUP, 8'h41, 8'h00, 1'b0);
    send_access(lrutlb_pkg::OP_INSERT, 8'h41, 8'h46, 1'b1);

    write_capacity(5'd31);
    send_access(lrutlb_pkg::OP_INSERT, 8'h55, 8'hAA, 1'b1);
    send_access(lrutlb_pkg::OP_INSERT, 8'hAA, 8'h55, 1'b0);
    send_access(lrutlb_pkg::OP_LOOKUP, 8'h55, 8'h00, 1'b0);

    page_base = 8'($urandom_range(0, 255));
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      write_capacity(phase_caps[ph]);
      if ($urandom_range(0, 1) == 0) page_base = 8'($urandom_range(0, 255));
      span = int'(phase_caps[ph]) + 4;
      if (span > 24) span = 24;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 4) == 0) page = 8'($urandom_range(0, 255));
        else page = page_base + 8'($urandom_range(0, span));
        op = ($urandom_range(0, 1) == 0) ? lrutlb_pkg::OP_LOOKUP : lrutlb_pkg::OP_INSERT;
        paced_access(op, page, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        if (ph == 2 && n == PHASE_ITEMS / 2) drain_responses();
      end
    end

    drain_responses();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && responses_due == 0) begin
      $display("lru_tlb_with_dirty_writeback regression: pass");
    end else begin
      $display("lru_tlb_with_dirty_writeback regression: fail");
    end
    $finish;
  end

endmodule
